FILE: rtl/core/euep_pkg.sv
// ----------------------------------------------------------------------------
// euep_pkg: shared types and constants for the utterance endpointer
// Widths of counters, energy sums and timestamps, control encodings, the
// request/response bundle of the RMS unit and register reset values.
// ----------------------------------------------------------------------------
package euep_pkg;

  localparam int CNT_W      = 19;   // sample counts and length registers
  localparam int SUM_W      = 49;   // energy sums, Q30 squares accumulated
  localparam int SQ_W       = 31;   // one squared sample brought to 30 fraction bits
  localparam int TIME_W     = 64;
  localparam int LEVEL_W    = 16;   // RMS in Q0.16
  localparam int THR_W      = 16;
  localparam int DVD_W      = SUM_W + 2;  // 4 * sum
  localparam int REM_W      = 19;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 19;
  localparam int M_TDATA_W  = 168;

  localparam int DIV_STEPS  = DVD_W;      // one quotient bit per step
  localparam int ROOT_STEPS = 16;         // one root bit per step over a 32-bit radicand
  localparam int STEP_W     = 6;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [SQ_W-1:0]    sq_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [THR_W-1:0]   thr_t;
  typedef logic [DVD_W-1:0]   dvd_t;
  typedef logic [REM_W-1:0]   rem_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [CNT_W:0]     cnt_wide_t;
  typedef logic [CNT_W:0]     loud_t;     // RMS * 10 and threshold * 11

  localparam cnt_t   CNT_MAX   = '1;
  localparam level_t LEVEL_MAX = '1;

  localparam loud_t LOUD_RMS_MUL = 20'd10;
  localparam loud_t LOUD_THR_MUL = 20'd11;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SPEECH_THR  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SILENCE_THR = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_BUFFER  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPEECH  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PREFERRED   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FORCE       = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_END_SILENCE = 3'd6;

  localparam thr_t RST_SPEECH_THR  = 16'd262;
  localparam thr_t RST_SILENCE_THR = 16'd524;
  localparam cnt_t RST_MIN_BUFFER  = 19'd8000;
  localparam cnt_t RST_MIN_SPEECH  = 19'd8000;
  localparam cnt_t RST_PREFERRED   = 19'd32000;
  localparam cnt_t RST_FORCE       = 19'd128000;
  localparam cnt_t RST_END_SILENCE = 19'd6400;

  typedef enum logic [1:0] {
    STAT_WAITING  = 2'd0,
    STAT_HELD     = 2'd1,
    STAT_DISCARD  = 2'd2,
    STAT_FINAL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_ACC,
    CTL_CRMS,
    CTL_CWAIT,
    CTL_BRMS,
    CTL_BWAIT,
    CTL_DECIDE,
    CTL_EMIT
  } ctl_state_t;

  typedef enum logic [1:0] {
    RMS_IDLE,
    RMS_DIV,
    RMS_ROOT
  } rms_state_t;

  typedef struct packed {
    logic start;
    sum_t sum;
    cnt_t count;
  } rms_req_t;

  typedef struct packed {
    logic   done;
    level_t level;
  } rms_rsp_t;

endpackage

FILE: rtl/core/euep_rms.sv
// ----------------------------------------------------------------------------
// euep_rms: iterative RMS unit
// floor(sqrt(floor(4*sum/count))) saturated to Q0.16, by a restoring divide
// and a digit-by-digit root that share one 20-bit subtractor.
// ----------------------------------------------------------------------------
module euep_rms (
  input  logic               clk,
  input  logic               rst,
  input  euep_pkg::rms_req_t req,
  output euep_pkg::rms_rsp_t rsp
);

  euep_pkg::rms_state_t state;
  euep_pkg::rms_state_t state_next;
  euep_pkg::step_t      step;
  euep_pkg::dvd_t       quo;
  euep_pkg::rem_t       rem;
  euep_pkg::level_t     root;
  euep_pkg::cnt_t       dvs;
  logic                 sat;
  logic                 done;
  euep_pkg::level_t     level;

  logic [19:0] op_a;
  logic [19:0] op_b;
  logic [20:0] diff;
  logic        ge;
  euep_pkg::rem_t   rem_next;
  euep_pkg::dvd_t   quo_div_next;
  euep_pkg::level_t root_next;
  logic        last_step;

  // shared subtractor: divisor trial in the divide, root trial in the root pass
  always_comb begin
    case (state)
      euep_pkg::RMS_DIV: begin
        op_a = {rem, quo[euep_pkg::DVD_W-1]};
        op_b = {1'b0, dvs};
      end
      euep_pkg::RMS_ROOT: begin
        op_a = {rem[17:0], quo[31:30]};
        op_b = {2'b00, root, 2'b01};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign diff         = {1'b0, op_a} - {1'b0, op_b};
  assign ge           = ~diff[20];
  assign rem_next     = ge ? diff[18:0] : op_a[18:0];
  assign quo_div_next = {quo[euep_pkg::DVD_W-2:0], ge};
  assign root_next    = {root[euep_pkg::LEVEL_W-2:0], ge};

  always_comb begin
    state_next = state;
    last_step  = 1'b0;
    case (state)
      euep_pkg::RMS_IDLE: begin
        if (req.start) state_next = euep_pkg::RMS_DIV;
      end
      euep_pkg::RMS_DIV: begin
        last_step = (step == euep_pkg::step_t'(euep_pkg::DIV_STEPS - 1));
        if (last_step) state_next = euep_pkg::RMS_ROOT;
      end
      euep_pkg::RMS_ROOT: begin
        last_step = (step == euep_pkg::step_t'(euep_pkg::ROOT_STEPS - 1));
        if (last_step) state_next = euep_pkg::RMS_IDLE;
      end
      default: state_next = euep_pkg::RMS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= euep_pkg::RMS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == euep_pkg::RMS_ROOT) && last_step;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      euep_pkg::RMS_IDLE: begin
        quo  <= {req.sum, 2'b00};
        dvs  <= req.count;
        rem  <= '0;
        root <= '0;
        step <= '0;
      end
      euep_pkg::RMS_DIV: begin
        quo <= quo_div_next;
        if (last_step) begin
          // quotient of 2^32 or more has a root past full scale
          sat  <= |quo_div_next[euep_pkg::DVD_W-1:32];
          rem  <= '0;
          step <= '0;
        end else begin
          rem  <= rem_next;
          step <= step + 1'b1;
        end
      end
      euep_pkg::RMS_ROOT: begin
        quo  <= quo << 2;
        rem  <= rem_next;
        root <= root_next;
        step <= step + 1'b1;
        if (last_step) begin
          if (dvs == '0) level <= '0;
          else if (sat) level <= euep_pkg::LEVEL_MAX;
          else level <= root_next;
        end
      end
      default: ;
    endcase
  end

  assign rsp.done  = done;
  assign rsp.level = level;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == euep_pkg::RMS_IDLE)
    else $error("rms start while busy");
  a_start_div: assert property (@(posedge clk) disable iff (rst)
    (req.start && state == euep_pkg::RMS_IDLE) |=> state == euep_pkg::RMS_DIV)
    else $error("rms start did not enter divide");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == euep_pkg::RMS_DIV && dvs != '0) |-> {1'b0, rem} < {1'b0, dvs})
    else $error("divide remainder not below divisor");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == euep_pkg::RMS_ROOT))
    else $error("rms done without root pass");
`endif

endmodule

FILE: rtl/core/energy_utterance_endpointer_core.sv
// ----------------------------------------------------------------------------
// energy_utterance_endpointer_core: energy-based utterance endpointer
// Accumulates sample energy per chunk and per buffered utterance; at each
// chunk end classifies the chunk and reports waiting, held, discarded or
// finalized with timestamps, length and buffer RMS.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Signals                        Meaning
//  s_*      in         s_tvalid s_tready s_tdata s_tlast  one sample; tlast = chunk end
//  m_*      out        m_tvalid m_tready m_tdata m_tuser  one decision per chunk end
//  cfg_*    in         cfg_we cfg_addr cfg_data           register writes, no read-back
//
//  Sequence: a sample that does not end a chunk is accepted, then accumulated.
//   A chunk end runs a chunk RMS pass, then a buffer RMS pass unless held;
//   each RMS pass in euep_rms is start, 51 divide steps, 16 root steps, result.
//  Stalls: s_tready is high only while the sequencer is idle; a finished result
//   waits in the load state until the output register frees.
//  Reset: synchronous, active high; restores register defaults, clears state.
// ----------------------------------------------------------------------------
module energy_utterance_endpointer_core #(
  parameter int MAX_BUFFER_SAMPLES = 320000,
  parameter int SAMPLE_BITS        = 16
) (
  input  logic clk,
  input  logic rst,

  // s_tdata, lowest bit first: sample [SAMPLE_BITS], chunk_time [64], zero pad
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  input  logic [((SAMPLE_BITS + 64 + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                                      s_tlast,

  // m_tdata, lowest bit first: level [16], start_time [64], end_time [64],
  //   utterance_length [19], zero pad [5]
  // m_tuser: status [2]
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [euep_pkg::M_TDATA_W-1:0]            m_tdata,
  output logic [1:0]                                m_tuser,

  input  logic                                      cfg_we,
  input  logic [euep_pkg::CFG_ADDR_W-1:0]           cfg_addr,
  input  logic [euep_pkg::CFG_DATA_W-1:0]           cfg_data
);

  localparam int MUL_W    = 2 * SAMPLE_BITS;
  // bring the square to 30 fraction bits whatever the sample width
  localparam int SQ_SHIFT = (SAMPLE_BITS >= 16) ? 2 * (SAMPLE_BITS - 16)
                                                : 2 * (16 - SAMPLE_BITS);
  localparam euep_pkg::cnt_t BUF_CAP = euep_pkg::cnt_t'(MAX_BUFFER_SAMPLES);

  // configuration
  euep_pkg::thr_t speech_thr;
  euep_pkg::thr_t silence_thr;
  euep_pkg::cnt_t min_buffer;
  euep_pkg::cnt_t min_speech;
  euep_pkg::cnt_t preferred;
  euep_pkg::cnt_t force_len;
  euep_pkg::cnt_t end_silence;

  // running state
  euep_pkg::cnt_t  buffer_count;
  euep_pkg::sum_t  buffer_sum;
  euep_pkg::cnt_t  chunk_count;
  euep_pkg::sum_t  chunk_sum;
  euep_pkg::cnt_t  speech_count;
  euep_pkg::cnt_t  silence_run;
  logic            utterance_active;
  euep_pkg::time_t first_time;
  euep_pkg::time_t last_time;

  euep_pkg::ctl_state_t state;
  euep_pkg::ctl_state_t state_next;

  // held sample
  euep_pkg::sq_t   sq;
  logic            end_flag;
  euep_pkg::time_t time_in;

  // decision
  euep_pkg::level_t  brms;
  euep_pkg::status_t res_status;
  euep_pkg::level_t  res_level;

  // output register
  euep_pkg::status_t out_status;
  euep_pkg::level_t  out_level;
  euep_pkg::time_t   out_start;
  euep_pkg::time_t   out_end;
  euep_pkg::cnt_t    out_len;

  euep_pkg::rms_req_t rms_req;
  euep_pkg::rms_rsp_t rms_rsp;

  logic [SAMPLE_BITS-1:0] in_sample;
  logic [SAMPLE_BITS-1:0] mag;
  logic [MUL_W-1:0]       sq_full;
  euep_pkg::sq_t          sq_norm;

  logic s_xfer;
  logic out_free;
  logic crms_speech;
  logic held;
  logic enough;
  logic sil_end;
  logic pref_hit;
  logic force_hit;
  logic clear_utt;
  euep_pkg::loud_t   brms_x10;
  euep_pkg::loud_t   thr_x11;
  euep_pkg::status_t dec_status;

  function automatic euep_pkg::cnt_t sat_add(euep_pkg::cnt_t a, euep_pkg::cnt_t b);
    euep_pkg::cnt_wide_t s;
    s = {1'b0, a} + {1'b0, b};
    return s[euep_pkg::CNT_W] ? euep_pkg::CNT_MAX : s[euep_pkg::CNT_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Square of the incoming sample, registered at accept
  // --------------------------------------------------------------------------
  assign in_sample = s_tdata[SAMPLE_BITS-1:0];
  // most negative code maps to 2^(SAMPLE_BITS-1), which still fits unsigned
  assign mag       = in_sample[SAMPLE_BITS-1]
                     ? (~in_sample + {{(SAMPLE_BITS-1){1'b0}}, 1'b1}) : in_sample;
  assign sq_full   = mag * mag;

  if (SAMPLE_BITS >= 16) begin : g_sq_down
    assign sq_norm = euep_pkg::sq_t'(sq_full >> SQ_SHIFT);
  end else begin : g_sq_up
    assign sq_norm = euep_pkg::sq_t'(sq_full) << SQ_SHIFT;
  end

  assign s_xfer   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // --------------------------------------------------------------------------
  // Decision terms
  // --------------------------------------------------------------------------
  // chunk RMS straight off the unit when the chunk pass finishes
  assign crms_speech = (rms_rsp.level >= speech_thr);
  assign held        = (rms_rsp.level < silence_thr) && (buffer_count < min_buffer);

  // loud buffer: RMS * 10 >= silence threshold * 11
  assign brms_x10  = euep_pkg::loud_t'(brms) * euep_pkg::LOUD_RMS_MUL;
  assign thr_x11   = euep_pkg::loud_t'(silence_thr) * euep_pkg::LOUD_THR_MUL;
  assign enough    = (speech_count >= min_speech) ||
                     ((buffer_count >= preferred) && (brms_x10 >= thr_x11));
  assign sil_end   = enough && (silence_run >= end_silence);
  assign pref_hit  = enough && (buffer_count >= preferred);
  assign force_hit = (buffer_count >= force_len);

  always_comb begin
    if (!sil_end && !pref_hit && !force_hit) dec_status = euep_pkg::STAT_WAITING;
    else if (!enough) dec_status = euep_pkg::STAT_DISCARD;
    else dec_status = euep_pkg::STAT_FINAL;
  end

  // discard and finalize drop the whole utterance once the result is loaded
  assign clear_utt = (state == euep_pkg::CTL_EMIT) && out_free &&
                     ((res_status == euep_pkg::STAT_DISCARD) ||
                      (res_status == euep_pkg::STAT_FINAL));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) state <= euep_pkg::CTL_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    rms_req.start = 1'b0;
    rms_req.sum   = chunk_sum;
    rms_req.count = chunk_count;
    case (state)
      euep_pkg::CTL_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = euep_pkg::CTL_ACC;
      end
      euep_pkg::CTL_ACC: begin
        state_next = end_flag ? euep_pkg::CTL_CRMS : euep_pkg::CTL_IDLE;
      end
      euep_pkg::CTL_CRMS: begin
        rms_req.start = 1'b1;
        state_next    = euep_pkg::CTL_CWAIT;
      end
      euep_pkg::CTL_CWAIT: begin
        if (rms_rsp.done) state_next = held ? euep_pkg::CTL_EMIT : euep_pkg::CTL_BRMS;
      end
      euep_pkg::CTL_BRMS: begin
        rms_req.start = 1'b1;
        rms_req.sum   = buffer_sum;
        rms_req.count = buffer_count;
        state_next    = euep_pkg::CTL_BWAIT;
      end
      euep_pkg::CTL_BWAIT: begin
        if (rms_rsp.done) state_next = euep_pkg::CTL_DECIDE;
      end
      euep_pkg::CTL_DECIDE: begin
        state_next = euep_pkg::CTL_EMIT;
      end
      euep_pkg::CTL_EMIT: begin
        if (out_free) state_next = euep_pkg::CTL_IDLE;
      end
      default: state_next = euep_pkg::CTL_IDLE;
    endcase
  end

  euep_rms u_rms (
    .clk (clk),
    .rst (rst),
    .req (rms_req),
    .rsp (rms_rsp)
  );

  // --------------------------------------------------------------------------
  // Configuration and running state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      speech_thr       <= euep_pkg::RST_SPEECH_THR;
      silence_thr      <= euep_pkg::RST_SILENCE_THR;
      min_buffer       <= euep_pkg::RST_MIN_BUFFER;
      min_speech       <= euep_pkg::RST_MIN_SPEECH;
      preferred        <= euep_pkg::RST_PREFERRED;
      force_len        <= euep_pkg::RST_FORCE;
      end_silence      <= euep_pkg::RST_END_SILENCE;
      buffer_count     <= '0;
      buffer_sum       <= '0;
      chunk_count      <= '0;
      chunk_sum        <= '0;
      speech_count     <= '0;
      silence_run      <= '0;
      utterance_active <= 1'b0;
      first_time       <= '0;
      last_time        <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      // thresholds take the low 16 bits; indexes past the list are dropped
      if (cfg_we) begin
        case (cfg_addr)
          euep_pkg::REG_SPEECH_THR:  speech_thr  <= cfg_data[euep_pkg::THR_W-1:0];
          euep_pkg::REG_SILENCE_THR: silence_thr <= cfg_data[euep_pkg::THR_W-1:0];
          euep_pkg::REG_MIN_BUFFER:  min_buffer  <= cfg_data;
          euep_pkg::REG_MIN_SPEECH:  min_speech  <= cfg_data;
          euep_pkg::REG_PREFERRED:   preferred   <= cfg_data;
          euep_pkg::REG_FORCE:       force_len   <= cfg_data;
          euep_pkg::REG_END_SILENCE: end_silence <= cfg_data;
          default: ;
        endcase
      end

      if (state == euep_pkg::CTL_ACC) begin
        // chunk counter saturates; buffer stops at its cap, no trim
        if (chunk_count != euep_pkg::CNT_MAX) begin
          chunk_count <= chunk_count + 1'b1;
          chunk_sum   <= chunk_sum + euep_pkg::sum_t'(sq);
        end
        if (buffer_count < BUF_CAP) begin
          buffer_count <= buffer_count + 1'b1;
          buffer_sum   <= buffer_sum + euep_pkg::sum_t'(sq);
        end
        if (end_flag) begin
          if (!utterance_active) begin
            first_time       <= time_in;
            utterance_active <= 1'b1;
          end
          last_time <= time_in;
        end
      end

      // chunk pass done: grow speech or silence run, then drop the chunk
      if (state == euep_pkg::CTL_CWAIT && rms_rsp.done) begin
        if (crms_speech) begin
          speech_count <= sat_add(speech_count, chunk_count);
          silence_run  <= '0;
        end else begin
          silence_run  <= sat_add(silence_run, chunk_count);
        end
        chunk_count <= '0;
        chunk_sum   <= '0;
      end

      if (clear_utt) begin
        buffer_count     <= '0;
        buffer_sum       <= '0;
        speech_count     <= '0;
        silence_run      <= '0;
        utterance_active <= 1'b0;
        first_time       <= '0;
        last_time        <= '0;
      end

      if (state == euep_pkg::CTL_EMIT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      sq       <= sq_norm;
      end_flag <= s_tlast;
      time_in  <= s_tdata[SAMPLE_BITS +: euep_pkg::TIME_W];
    end

    if (state == euep_pkg::CTL_CWAIT && rms_rsp.done) begin
      res_status <= euep_pkg::STAT_HELD;
      res_level  <= '0;
    end
    if (state == euep_pkg::CTL_BWAIT && rms_rsp.done) brms <= rms_rsp.level;
    if (state == euep_pkg::CTL_DECIDE) begin
      res_status <= dec_status;
      res_level  <= (dec_status == euep_pkg::STAT_DISCARD) ? '0 : brms;
    end

    // load from live state before any clear takes effect
    if (state == euep_pkg::CTL_EMIT && out_free) begin
      out_status <= res_status;
      out_level  <= res_level;
      out_start  <= first_time;
      out_end    <= last_time;
      out_len    <= buffer_count;
    end
  end

  assign m_tdata = {5'b0, out_len, out_end, out_start, out_level};
  assign m_tuser = out_status;

`ifndef NO_ASSERTIONS
  a_active_len: assert property (@(posedge clk) disable iff (rst)
    utterance_active |-> buffer_count != '0)
    else $error("active utterance with empty buffer");
  a_buf_cap: assert property (@(posedge clk) disable iff (rst)
    BUF_CAP >= buffer_count)
    else $error("buffer count past cap");
  a_rms_done: assert property (@(posedge clk) disable iff (rst)
    rms_rsp.done |-> (state == euep_pkg::CTL_CWAIT || state == euep_pkg::CTL_BWAIT))
    else $error("rms result outside a wait state");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    clear_utt |=> (buffer_count == '0 && speech_count == '0 && !utterance_active))
    else $error("utterance not cleared after discard or finalize");
  a_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == euep_pkg::CTL_EMIT))
    else $error("result shown without load");
`endif

endmodule

FILE: verif/euep_checker.sv
// ----------------------------------------------------------------------------
// euep_checker: scoreboard for the utterance endpointer core
// Watches the sample, decision and register-write channels, keeps its own copy
// of the registers and utterance state, predicts one decision per chunk end
// and compares every decision transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module euep_checker
  import euep_pkg::*;
#(
  parameter int MAX_BUFFER = 320000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [79:0]           s_tdata,
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,
  input  logic [1:0]            m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    open_count,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  typedef struct {
    status_t status;
    level_t  level;
    time_t   first_stamp;
    time_t   last_stamp;
    cnt_t    length;
  } decision_t;

  decision_t predicted_decisions[$];

  // register copy
  thr_t speech_thr;
  thr_t quiet_thr;
  cnt_t min_buffer;
  cnt_t min_speech;
  cnt_t preferred_len;
  cnt_t force_len;
  cnt_t end_silence;

  // utterance and chunk state
  cnt_t  buf_n;
  sum_t  buf_energy;
  cnt_t  chunk_n;
  sum_t  chunk_sq_sum;
  cnt_t  speech_n;
  cnt_t  quiet_run;
  logic  in_utterance;
  time_t first_stamp;
  time_t last_stamp;

  initial fail_count = 0;
  initial open_count = 0;

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] trial;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (64'd1 << b);
      if (trial * trial <= v) res = trial;
    end
    return res;
  endfunction

  // RMS in Q0.16 of a Q30 energy sum over n samples, saturated
  function automatic level_t rms_level(input sum_t energy, input cnt_t n);
    logic [63:0] mean_sq;
    logic [63:0] root;
    if (n == 0) return '0;
    mean_sq = (64'(energy) * 64'd4) / 64'(n);
    root = floor_root(mean_sq);
    return (root > 64'(LEVEL_MAX)) ? LEVEL_MAX : level_t'(root);
  endfunction

  function automatic cnt_t sat_count(input cnt_t a, input cnt_t b);
    logic [CNT_W:0] s;
    s = a + b;
    return (s > CNT_MAX) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  task automatic clear_utterance();
    buf_n = '0;
    buf_energy = '0;
    speech_n = '0;
    quiet_run = '0;
    in_utterance = 1'b0;
    first_stamp = '0;
    last_stamp = '0;
  endtask

  task automatic reset_endpointer();
    speech_thr = RST_SPEECH_THR;
    quiet_thr = RST_SILENCE_THR;
    min_buffer = RST_MIN_BUFFER;
    min_speech = RST_MIN_SPEECH;
    preferred_len = RST_PREFERRED;
    force_len = RST_FORCE;
    end_silence = RST_END_SILENCE;
    clear_utterance();
    chunk_n = '0;
    chunk_sq_sum = '0;
  endtask

  task automatic apply_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_SPEECH_THR:  speech_thr = val[THR_W-1:0];
      REG_SILENCE_THR: quiet_thr = val[THR_W-1:0];
      REG_MIN_BUFFER:  min_buffer = val;
      REG_MIN_SPEECH:  min_speech = val;
      REG_PREFERRED:   preferred_len = val;
      REG_FORCE:       force_len = val;
      REG_END_SILENCE: end_silence = val;
      default: ;
    endcase
  endtask

  // Advance the endpointer by one sample; queue a decision at chunk end.
  task automatic take_sample(input logic [15:0] raw, input logic chunk_end, input time_t stamp);
    logic [16:0] mag;
    logic [31:0] sq;
    level_t      chunk_rms;
    level_t      buf_rms;
    logic        enough;
    logic        quiet_end;
    logic        long_enough;
    logic        forced;
    decision_t   d;
    mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    sq = mag * mag;
    if (chunk_n < CNT_MAX) begin
      chunk_n = chunk_n + 1'b1;
      chunk_sq_sum = chunk_sq_sum + sq;
    end
    if (buf_n < MAX_BUFFER) begin
      buf_n = buf_n + 1'b1;
      buf_energy = buf_energy + sq;
    end
    if (!chunk_end) return;

    if (!in_utterance) begin
      first_stamp = stamp;
      in_utterance = 1'b1;
    end
    last_stamp = stamp;

    chunk_rms = rms_level(chunk_sq_sum, chunk_n);
    if (chunk_rms >= speech_thr) begin
      speech_n = sat_count(speech_n, chunk_n);
      quiet_run = '0;
    end else begin
      quiet_run = sat_count(quiet_run, chunk_n);
    end
    chunk_n = '0;
    chunk_sq_sum = '0;

    d.first_stamp = first_stamp;
    d.last_stamp = last_stamp;
    d.length = buf_n;

    // short and quiet: hold the buffer
    if (chunk_rms < quiet_thr && buf_n < min_buffer) begin
      d.status = STAT_HELD;
      d.level = '0;
      predicted_decisions.insert(predicted_decisions.size(), d);
      return;
    end

    buf_rms = rms_level(buf_energy, buf_n);
    enough = (speech_n >= min_speech) ||
             (buf_n >= preferred_len &&
              ({4'd0, buf_rms} * 20'd10) >= ({4'd0, quiet_thr} * 20'd11));
    quiet_end = enough && quiet_run >= end_silence;
    long_enough = enough && buf_n >= preferred_len;
    forced = buf_n >= force_len;

    if (!quiet_end && !long_enough && !forced) begin
      d.status = STAT_WAITING;
      d.level = buf_rms;
    end else if (!enough) begin
      d.status = STAT_DISCARD;
      d.level = '0;
      clear_utterance();
    end else begin
      d.status = STAT_FINAL;
      d.level = buf_rms;
      clear_utterance();
    end
    predicted_decisions.insert(predicted_decisions.size(), d);
  endtask

  task automatic check_decision();
    decision_t want;
    status_t   got_status;
    level_t    got_level;
    time_t     got_first;
    time_t     got_last;
    cnt_t      got_length;
    got_status = status_t'(m_tuser);
    got_level  = m_tdata[15:0];
    got_first  = m_tdata[79:16];
    got_last   = m_tdata[143:80];
    got_length = m_tdata[162:144];
    if (predicted_decisions.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: decision transfer with nothing predicted: status %0d level %0d",
                 $realtime, got_status, got_level);
      return;
    end
    want = predicted_decisions.pop_front();
    if (got_status !== want.status || got_level !== want.level ||
        got_first !== want.first_stamp || got_last !== want.last_stamp ||
        got_length !== want.length) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: decision mismatch (expected/actual) status %0d/%0d level %0d/%0d",
                 $realtime, want.status, got_status, want.level, got_level,
                 " start %0h/%0h end %0h/%0h length %0d/%0d",
                 want.first_stamp, got_first, want.last_stamp, got_last,
                 want.length, got_length);
    end
  endtask

  // Compare the outgoing transfer before the incoming one: a decision can
  // never belong to a sample taken at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      reset_endpointer();
      predicted_decisions.delete();
    end else begin
      if (cfg_we) apply_write(cfg_addr, cfg_data);
      if (m_tvalid && m_tready) check_decision();
      if (s_tvalid && s_tready) take_sample(s_tdata[15:0], s_tlast, s_tdata[79:16]);
    end
    open_count <= predicted_decisions.size();
  end

endmodule

FILE: verif/tb_energy_utterance_endpointer_core.sv
// ----------------------------------------------------------------------------
// tb_energy_utterance_endpointer_core: top of the endpointer testbench
// Drives samples and register writes into the core, stalls the decision side
// at random, and leaves prediction and comparison to euep_checker. Directed
// chunks cover field extremes and all four decision kinds; a force length
// past the buffer cap is exercised; random phases send speech-then-silence
// utterances under changing thresholds and lengths.
// ----------------------------------------------------------------------------
module tb_energy_utterance_endpointer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import euep_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_BUFFER     = 320000;
  localparam int SAMPLE_BITS    = 16;
  localparam int S_TDATA_W      = ((SAMPLE_BITS + 64 + 7) / 8) * 8;
  localparam int GAP_PERCENT    = 21;
  localparam int HOLD_CYCLES    = 600;     // long decision-side hold-off
  localparam int SETTLE_CYCLES  = 16;      // covers a non-final sample still in flight
  localparam int END_SETTLE     = 300;     // covers one chunk-end decision
  localparam int WATCHDOG_LIMIT = 5000;    // hold-off plus several chunk ends
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_SAMPLES  = 170;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {
    KIND_LOUD,
    KIND_QUIET,
    KIND_NOISE
  } chunk_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic gaps_on = 1'b1;       // random idling on both sides
  logic sink_hold_go = 1'b0;  // ask the decision side for its long hold-off
  logic hold_served = 1'b0;
  int   hold_left = 0;
  int   idle_cycles = 0;
  int   open_count;
  int   fail_count;

  always #(CLK_PERIOD / 2) clk = ~clk;

  energy_utterance_endpointer_core #(
    .MAX_BUFFER_SAMPLES (MAX_BUFFER),
    .SAMPLE_BITS        (SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  euep_checker #(
    .MAX_BUFFER (MAX_BUFFER)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .open_count (open_count),
    .fail_count (fail_count)
  );

  // Decision side: random stalls, plus one long hold-off counted here. While
  // it lasts the sender keeps offering samples, so one decision parks in the
  // output register, the next waits inside the core and s_tready drops.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (sink_hold_go && !hold_served) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= 1'b1;
    end else begin
      m_tready <= gaps_on ? ($urandom_range(99) >= GAP_PERCENT) : 1'b1;
    end
  end

  // Watchdog: end the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one sample, idling first at random; return at the edge that
  // takes the transfer, with s_tvalid still high.
  task automatic send_sample(input logic [15:0] smp, input logic last, input time_t stamp);
    while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {stamp, smp};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample(input chunk_kind_t kind);
    logic [15:0] mag;
    case (kind)
      KIND_LOUD:  mag = 16'($urandom_range(2000, 32767));
      KIND_QUIET: mag = 16'($urandom_range(0, 40));
      default:    return 16'($urandom);
    endcase
    return $urandom_range(1) ? -mag : mag;
  endfunction

  task automatic send_chunk(input chunk_kind_t kind, input int len, input time_t stamp);
    for (int i = 0; i < len; i++) send_sample(pick_sample(kind), i == len - 1, stamp);
  endtask

  // Pause the sender until every predicted decision is out, then let the
  // core finish any sample still in flight.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Write all registers back to back, plus a stray write past the last index
  // that the core must ignore.
  task automatic load_settings(input logic [18:0] speech, input logic [18:0] quiet,
                               input logic [18:0] min_buf, input logic [18:0] min_sp,
                               input logic [18:0] pref, input logic [18:0] force_len,
                               input logic [18:0] end_sil);
    write_reg(REG_SPEECH_THR, speech);
    write_reg(REG_SILENCE_THR, quiet);
    write_reg(REG_MIN_BUFFER, min_buf);
    write_reg(REG_MIN_SPEECH, min_sp);
    write_reg(REG_PREFERRED, pref);
    write_reg(REG_FORCE, force_len);
    write_reg(REG_END_SILENCE, end_sil);
    write_reg(REG_UNUSED, 19'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    time_t       clock_ns;
    time_t       stamp;
    chunk_kind_t kind;
    int          sent;
    int          n_loud;
    int          n_quiet;
    int          len;
    logic        reversed;

    clock_ns = 64'd1_000_000;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: single-sample chunks at full scale (one saturates the
    // chunk level), then a short quiet chunk that gets held.
    send_sample(16'h7FFF, 1'b1, '0);
    send_sample(16'h8000, 1'b1, '1);
    send_sample(16'h0000, 1'b0, 64'd5);
    send_sample(16'h0000, 1'b0, 64'd5);
    send_sample(16'h0001, 1'b0, 64'd5);
    send_sample(16'hFFFF, 1'b1, 64'd5);
    drain_results();

    // Tiny lengths: finalize on trailing silence, discard a quiet buffer at
    // the force length, wait on speech, finalize again. The speech threshold
    // is written with high bits set that the 16-bit register drops.
    load_settings(19'h70106, 19'd524, 19'd0, 19'd3, 19'd8, 19'd10, 19'd2);
    send_chunk(KIND_QUIET, 2, 64'd100);
    send_chunk(KIND_QUIET, 10, 64'd200);
    send_sample(16'h8000, 1'b0, 64'd300);
    send_sample(16'h7FFF, 1'b0, 64'd300);
    send_sample(16'h8000, 1'b1, 64'd300);
    send_chunk(KIND_QUIET, 2, 64'd400);
    drain_results();

    // Force and preferred lengths past the buffer cap never trigger; a quiet
    // chunk is reported as waiting, since neither speech nor length is enough.
    load_settings(19'd262, 19'd524, 19'd0, 19'd100, 19'h7FFFF, 19'h7FFFF, 19'd1);
    send_chunk(KIND_QUIET, 3, clock_ns);
    drain_results();

    // Random phases: mostly speech followed by silence, some reversed
    // utterances and full-range noise chunks mixed in.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      if (phase == 0) begin
        load_settings('0, '0, '0, '0, '0, '0, '0);
      end else if (phase == RANDOM_PHASES - 1) begin
        load_settings(19'hFFFF, 19'hFFFF, '1, '1, '1, '1, '1);
      end else begin
        load_settings(19'($urandom_range(100, 3000)), 19'($urandom_range(100, 4000)),
                      19'($urandom_range(0, 100)), 19'($urandom_range(1, 120)),
                      19'($urandom_range(30, 300)), 19'($urandom_range(60, 500)),
                      19'($urandom_range(0, 80)));
      end
      // keep the first random phase free of idling, idle at random afterwards
      gaps_on <= (phase != 0);
      if (phase == 2) sink_hold_go <= 1'b1;

      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        n_loud = $urandom_range(1, 5);
        n_quiet = $urandom_range(1, 6);
        reversed = ($urandom_range(9) == 0);
        for (int k = 0; k < n_loud + n_quiet; k++) begin
          len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
          if ($urandom_range(99) < 15)
            kind = KIND_NOISE;
          else if ((k < n_loud) != reversed)
            kind = KIND_LOUD;
          else
            kind = KIND_QUIET;
          stamp = ($urandom_range(7) == 0) ? {$urandom, $urandom} : clock_ns;
          clock_ns = clock_ns + 64'd20_000_000;
          send_chunk(kind, len, stamp);
          sent += len;
        end
      end
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (fail_count == 0 && open_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
